// ----- rtl/tcp_option_parser_top_macros.svh -----
// Assertion macros for the TCP option parser.
`ifndef TCP_OPTION_PARSER_TOP_MACROS_SVH
`define TCP_OPTION_PARSER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcp option parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TOP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcp option parser assertion failed");

`endif

// ----- rtl/tcpop_pkg.sv -----
// Package with the types and constants of the TCP option parser.
`default_nettype none

package tcpop_pkg;

	localparam logic [3:0] WSCALE_MAX = 4'd14;

	localparam logic [15:0] RST_LOCAL_RCV_MSS = 16'd1460;
	localparam logic [15:0] RST_MIN_MSS       = 16'd88;
	localparam logic [15:0] RST_DEFAULT_MSS   = 16'd1460;

	localparam logic [1:0] CFG_LOCAL_RCV_MSS = 2'd0;
	localparam logic [1:0] CFG_MIN_MSS       = 2'd1;
	localparam logic [1:0] CFG_DEFAULT_MSS   = 2'd2;

	localparam logic [7:0] KIND_EOL    = 8'd0;
	localparam logic [7:0] KIND_NOP    = 8'd1;
	localparam logic [7:0] KIND_MSS    = 8'd2;
	localparam logic [7:0] KIND_WSCALE = 8'd3;
	localparam logic [7:0] LEN_MSS     = 8'd4;
	localparam logic [7:0] LEN_WSCALE  = 8'd3;
	localparam logic [7:0] LEN_MIN     = 8'd2;

	typedef enum logic [2:0] {
		PH_KIND = 3'b001,
		PH_LEN  = 3'b010,
		PH_DATA = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		OPT_OTHER  = 2'd0,
		OPT_MSS    = 2'd1,
		OPT_WSCALE = 2'd2
	} opt_kind_t;

	typedef struct packed {
		logic [7:0] opt_byte;
		logic       byte_valid;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] send_mss;
		logic [3:0]  send_wscale;
		logic        mss_present;
		logic        wscale_present;
		logic        malformed;
	} out_item_t;

	typedef struct packed {
		logic        mss_seen;
		logic        wscale_seen;
		logic        bad;
		logic [15:0] mss_value;
		logic [3:0]  wscale_value;
	} parse_view_t;

endpackage

`default_nettype wire

// ----- rtl/tcp_option_parser_top.sv -----
// Top level of the TCP option parser for SYN segments.
// The block walks a TCP options area one byte per request and, on the request
// marked last, delivers one result with the send MSS, the peer window scale and
// the presence and malformed flags. It accepts one request per clock cycle while
// the input is not held back. A request is registered on acceptance; the option
// state and the MSS clamp are worked out from that register combinationally,
// and the result register loads the answer as the last request leaves it.
// Only a last request waiting behind a stalled, occupied result register holds
// the input back. Configuration writes must be made while no options area is in
// progress and no result is waiting.
`default_nettype none

`include "tcp_option_parser_top_macros.svh"

module tcp_option_parser_top import tcpop_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] local_rcv_mss_q;
	logic [15:0] min_mss_q;
	logic [15:0] default_mss_q;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        adv_s1;
	logic        step_s1;
	logic        load_ok;
	parse_view_t view;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_rcv_mss_q <= RST_LOCAL_RCV_MSS;
			min_mss_q       <= RST_MIN_MSS;
			default_mss_q   <= RST_DEFAULT_MSS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCAL_RCV_MSS: local_rcv_mss_q <= cfg_data;
				CFG_MIN_MSS:       min_mss_q       <= cfg_data;
				CFG_DEFAULT_MSS:   default_mss_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s1   = !item_s1.is_last || load_ok;
	assign step_s1  = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	tcpop_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_s1),
		.item   (item_s1),
		.view   (view)
	);

	tcpop_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_req      (step_s1 && item_s1.is_last),
		.view          (view),
		.local_rcv_mss (local_rcv_mss_q),
		.min_mss       (min_mss_q),
		.default_mss   (default_mss_q),
		.out_stall     (out_stall),
		.load_ok       (load_ok),
		.out_valid     (out_valid),
		.out_data      (out_data)
	);

	`TOP_ASSERT_NOW(a_stall_only_on_last, in_stall, valid_s1 && item_s1.is_last && out_valid)
	`TOP_ASSERT_NEXT(a_last_gives_result, step_s1 && item_s1.is_last, out_valid)
	`TOP_ASSERT_NOW(a_mss_clamped, out_valid && out_data.mss_present && min_mss_q <= local_rcv_mss_q, out_data.send_mss >= min_mss_q && out_data.send_mss <= local_rcv_mss_q)

endmodule

`default_nettype wire

// ----- rtl/tcpop_parser.sv -----
// Option walker that tracks the parse state byte by byte.
`default_nettype none

module tcpop_parser import tcpop_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_item_t    item,
	output parse_view_t view
);

	phase_t      phase_q, phase_n;
	opt_kind_t   kind_q, kind_n;
	logic [7:0]  left_q, left_n;
	logic        idx_q, idx_n;
	logic [7:0]  mss_hi_q, mss_hi_n;
	logic [15:0] mss_q, mss_n;
	logic [3:0]  ws_q, ws_n;
	logic        mss_seen_q, mss_seen_n;
	logic        ws_seen_q, ws_seen_n;
	logic        bad_q, bad_n;
	logic        stopped_q, stopped_n;
	logic [7:0]  b;

	assign b = item.opt_byte;

	always_comb begin
		phase_n    = phase_q;
		kind_n     = kind_q;
		left_n     = left_q;
		idx_n      = idx_q;
		mss_hi_n   = mss_hi_q;
		mss_n      = mss_q;
		ws_n       = ws_q;
		mss_seen_n = mss_seen_q;
		ws_seen_n  = ws_seen_q;
		bad_n      = bad_q;
		stopped_n  = stopped_q;
		if (item.byte_valid && !stopped_q) begin
			unique case (phase_q)
				PH_LEN: begin
					if (b < LEN_MIN) begin
						bad_n     = 1'b1;
						stopped_n = 1'b1;
					end else begin
						if (kind_q == OPT_MSS && b == LEN_MSS) begin
							kind_n = OPT_MSS;
						end else if (kind_q == OPT_WSCALE && b == LEN_WSCALE) begin
							kind_n = OPT_WSCALE;
						end else begin
							kind_n = OPT_OTHER;
						end
						left_n  = b - LEN_MIN;
						idx_n   = 1'b0;
						phase_n = (b == LEN_MIN) ? PH_KIND : PH_DATA;
					end
				end
				PH_DATA: begin
					if (kind_q == OPT_MSS) begin
						if (!idx_q) begin
							mss_hi_n = b;
						end else begin
							mss_n      = {mss_hi_q, b};
							mss_seen_n = 1'b1;
						end
					end else if (kind_q == OPT_WSCALE) begin
						ws_n      = (b > {4'd0, WSCALE_MAX}) ? WSCALE_MAX : b[3:0];
						ws_seen_n = 1'b1;
					end
					idx_n  = 1'b1;
					left_n = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_n = PH_KIND;
					end
				end
				default: begin
					if (b == KIND_EOL) begin
						stopped_n = 1'b1;
					end else if (b != KIND_NOP) begin
						if (b == KIND_MSS) begin
							kind_n = OPT_MSS;
						end else if (b == KIND_WSCALE) begin
							kind_n = OPT_WSCALE;
						end else begin
							kind_n = OPT_OTHER;
						end
						phase_n = PH_LEN;
					end
				end
			endcase
		end
	end

	assign view = '{
		mss_seen:     mss_seen_n,
		wscale_seen:  ws_seen_n,
		bad:          bad_n,
		mss_value:    mss_n,
		wscale_value: ws_n
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_KIND;
			kind_q     <= OPT_OTHER;
			left_q     <= 8'd0;
			idx_q      <= 1'b0;
			mss_seen_q <= 1'b0;
			ws_seen_q  <= 1'b0;
			bad_q      <= 1'b0;
			stopped_q  <= 1'b0;
		end else if (step) begin
			if (item.is_last) begin
				phase_q    <= PH_KIND;
				kind_q     <= OPT_OTHER;
				left_q     <= 8'd0;
				idx_q      <= 1'b0;
				mss_seen_q <= 1'b0;
				ws_seen_q  <= 1'b0;
				bad_q      <= 1'b0;
				stopped_q  <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				kind_q     <= kind_n;
				left_q     <= left_n;
				idx_q      <= idx_n;
				mss_seen_q <= mss_seen_n;
				ws_seen_q  <= ws_seen_n;
				bad_q      <= bad_n;
				stopped_q  <= stopped_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mss_hi_q <= mss_hi_n;
			mss_q    <= mss_n;
			ws_q     <= ws_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tcpop_result.sv -----
// Send MSS clamp and result register of the TCP option parser.
`default_nettype none

module tcpop_result import tcpop_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load_req,
	input  parse_view_t view,
	input  logic [15:0] local_rcv_mss,
	input  logic [15:0] min_mss,
	input  logic [15:0] default_mss,
	input  logic        out_stall,
	output logic        load_ok,
	output logic        out_valid,
	output out_item_t   out_data
);

	logic        valid_q;
	out_item_t   data_q;
	logic [15:0] floor_mss;
	logic [15:0] clamp_mss;
	out_item_t   res;

	assign floor_mss = (view.mss_value > min_mss) ? view.mss_value : min_mss;
	assign clamp_mss = (floor_mss > local_rcv_mss) ? local_rcv_mss : floor_mss;

	assign res = '{
		send_mss:       view.mss_seen ? clamp_mss : default_mss,
		send_wscale:    view.wscale_seen ? view.wscale_value : 4'd0,
		mss_present:    view.mss_seen,
		wscale_present: view.wscale_seen,
		malformed:      view.bad
	};

	assign load_ok = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_req && load_ok) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req && load_ok) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire
